>>> design/umpq_pkg.sv
// ----------------------------------------------------------------------------
// umpq_pkg: shared types and helpers for the UTF-8 MPQ string hash
// Beat structs, command codes, sequencer states and the UTF-8 byte picker.
// ----------------------------------------------------------------------------
package umpq_pkg;

  localparam int unsigned TableDepth = 512;
  localparam int unsigned TableWidth = 32;
  localparam int unsigned RowWords   = 256;

  localparam logic [31:0] SEED_FIRST_INIT  = 32'h7FED7FED;
  localparam logic [31:0] SEED_SECOND_INIT = 32'hEEEEEEEE;

  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] ASCII_MASK = 8'h7F;
  localparam logic [7:0] LOW6_MASK  = 8'h3F;
  localparam logic [7:0] LOW5_MASK  = 8'h1F;
  localparam logic [7:0] LOW4_MASK  = 8'h0F;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_START  = 2'd1,
    CMD_FEED   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_UPD_B,
    ST_EMIT
  } state_t;

  typedef struct packed {
    cmd_t        command;
    logic [8:0]  table_index;
    logic [31:0] table_word;
    logic [15:0] code_unit;
  } in_item_t;

  typedef struct packed {
    logic [31:0] hash_a;
    logic [31:0] hash_b;
  } out_item_t;

  // Number of UTF-8 bytes for one code unit, minus one.
  function automatic logic [1:0] utf8_last(input logic [15:0] u);
    logic [1:0] r;
    if (u < 16'h0080) begin
      r = 2'd0;
    end else if (u < 16'h0800) begin
      r = 2'd1;
    end else begin
      r = 2'd2;
    end
    return r;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end else begin
      r = c;
    end
    return r;
  endfunction

  // Byte number idx of the UTF-8 encoding of u, already upper-cased.
  function automatic logic [7:0] utf8_byte(input logic [15:0] u, input logic [1:0] idx);
    logic [7:0] b;
    if (u < 16'h0080) begin
      b = upcase(u[7:0] & ASCII_MASK);
    end else if (u < 16'h0800) begin
      if (idx == 2'd0) begin
        b = LEAD2_MARK | ({3'b000, u[10:6]} & LOW5_MASK);
      end else begin
        b = CONT_MARK | ({2'b00, u[5:0]} & LOW6_MASK);
      end
    end else begin
      case (idx)
        2'd0:    b = LEAD3_MARK | ({4'b0000, u[15:12]} & LOW4_MASK);
        2'd1:    b = CONT_MARK | ({2'b00, u[11:6]} & LOW6_MASK);
        default: b = CONT_MARK | ({2'b00, u[5:0]} & LOW6_MASK);
      endcase
    end
    return b;
  endfunction

endpackage

>>> design/umpq_ram.sv
// ----------------------------------------------------------------------------
// umpq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module umpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/utf8_mpq_string_hash.sv
// ----------------------------------------------------------------------------
// utf8_mpq_string_hash: dual-chain MPQ hash over UTF-8 encoded code units
// Table loader, byte sequencer and one shared chain-step unit.
// ----------------------------------------------------------------------------
// A load beat writes one word of the 512-word crypt table (row A at 0-255,
// row B at 256-511); a start beat resets both seed pairs. A feed beat
// encodes its code unit as one, two or three UTF-8 bytes and runs every
// byte through chain A and then chain B: each byte passes through ST_RD_A,
// ST_RD_B and ST_UPD_B, and the block takes no new beat until the last byte
// is done. This is set by the single read port of the crypt table and the
// one chain-step unit that both chains share: each byte needs a row A read,
// a row B read and two dependent seed updates. A finish beat puts
// (hash_a, hash_b) into the output register; if an earlier result still
// waits there, the block holds in a wait state until that beat leaves.
// Finish does not disturb the seeds. Table words that were never loaded read
// as unknown data. No clearing pass follows reset: the block is ready as
// soon as rst_n rises.
// ----------------------------------------------------------------------------
module utf8_mpq_string_hash (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  umpq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output umpq_pkg::out_item_t out_data
);
  import umpq_pkg::*;

  localparam int unsigned AddrW = $clog2(TableDepth);

  state_t      state_r, state_nxt;
  logic [31:0] sa1_r, sa1_nxt, sa2_r, sa2_nxt;
  logic [31:0] sb1_r, sb1_nxt, sb2_r, sb2_nxt;
  logic [15:0] cu_r, cu_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic             in_beat;
  logic             out_free;
  logic [7:0]       cur_byte;
  logic             last_byte;
  logic             ram_we;
  logic [AddrW-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  // Shared chain-step unit operands and results.
  logic        sel_b;
  logic [31:0] s1_sel, s2_sel, step_n1, step_n2;

  assign in_beat   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cur_byte  = utf8_byte(cu_r, idx_r);
  assign last_byte = (idx_r == utf8_last(cu_r));

  // Table loads go straight to the write port; reads come only from the
  // sequencer, so the two never collide on an address of interest.
  assign ram_we = in_beat && (in_data.command == CMD_LOAD);

  always_comb begin
    ram_raddr = {1'b0, cur_byte};
    if (state_r == ST_RD_B) begin
      ram_raddr = {1'b1, cur_byte};
    end
  end

  umpq_ram #(
    .WIDTH (TableWidth),
    .DEPTH (TableDepth)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.table_index),
    .wdata (in_data.table_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // One chain step: row A data lands in ST_RD_B, row B data in ST_UPD_B.
  assign sel_b   = (state_r == ST_UPD_B);
  assign s1_sel  = sel_b ? sb1_r : sa1_r;
  assign s2_sel  = sel_b ? sb2_r : sa2_r;
  assign step_n1 = ram_rdata ^ (s1_sel + s2_sel);
  assign step_n2 = {24'd0, cur_byte} + step_n1 + s2_sel + (s2_sel << 5) + 32'd3;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    sa1_nxt       = sa1_r;
    sa2_nxt       = sa2_r;
    sb1_nxt       = sb1_r;
    sb2_nxt       = sb2_r;
    cu_nxt        = cu_r;
    idx_nxt       = idx_r;
    out_data_nxt  = out_data_r;
    // Drop the held beat once the consumer takes it.
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.command)
            CMD_START: begin
              sa1_nxt = SEED_FIRST_INIT;
              sa2_nxt = SEED_SECOND_INIT;
              sb1_nxt = SEED_FIRST_INIT;
              sb2_nxt = SEED_SECOND_INIT;
            end
            CMD_FEED: begin
              cu_nxt    = in_data.code_unit;
              idx_nxt   = 2'd0;
              state_nxt = ST_RD_A;
            end
            CMD_FINISH: begin
              if (out_free) begin
                out_data_nxt  = '{hash_a: sa1_r, hash_b: sb1_r};
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_EMIT;
              end
            end
            default: begin
              // load: the write port takes the word this cycle
            end
          endcase
        end
      end
      ST_RD_A: begin
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        sa1_nxt   = step_n1;
        sa2_nxt   = step_n2;
        state_nxt = ST_UPD_B;
      end
      ST_UPD_B: begin
        sb1_nxt = step_n1;
        sb2_nxt = step_n2;
        if (last_byte) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_RD_A;
        end
      end
      ST_EMIT: begin
        // Hold until the output register frees up; seeds cannot move here.
        if (out_free) begin
          out_data_nxt  = '{hash_a: sa1_r, hash_b: sb1_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sa1_r       <= SEED_FIRST_INIT;
      sa2_r       <= SEED_SECOND_INIT;
      sb1_r       <= SEED_FIRST_INIT;
      sb2_r       <= SEED_SECOND_INIT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sa1_r       <= sa1_nxt;
      sa2_r       <= sa2_nxt;
      sb1_r       <= sb1_nxt;
      sb2_r       <= sb2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cu_r       <= cu_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> design/umpq_checker.sv
// ----------------------------------------------------------------------------
// umpq_checker: port-level checks for the UTF-8 MPQ string hash
// Watches both channels over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module umpq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input umpq_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input umpq_pkg::out_item_t out_data
);
  import umpq_pkg::*;

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A feed keeps the block busy while its bytes go through the chains.
  a_feed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == CMD_FEED |=> !in_ready)
    else $error("ready right after a feed beat");

  // A finish with a free output slot shows its result next cycle.
  a_finish_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == CMD_FINISH && !out_valid |=> out_valid)
    else $error("finish produced no result");

  // After a load or a start the block is ready again in the next cycle.
  a_quick_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_data.command == CMD_LOAD || in_data.command == CMD_START) |=> in_ready)
    else $error("load or start left the block busy");

endmodule

bind utf8_mpq_string_hash umpq_checker u_umpq_checker (.*);

>>> tb/sv/utf8_mpq_string_hash_checker.sv
// ----------------------------------------------------------------------------
// utf8_mpq_string_hash_checker: scoreboard for the UTF-8 MPQ string hash
// Mirrors the crypt table and both seed pairs from the accepted input beats,
// queues the hashes each finish should emit and compares every result beat.
// ----------------------------------------------------------------------------
module utf8_mpq_string_hash_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  umpq_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  umpq_pkg::out_item_t out_data,
  output int unsigned         mismatches,
  output int unsigned         awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import umpq_pkg::*;

  logic [31:0] crypt_shadow [TableDepth];
  logic [31:0] a_first, a_second, b_first, b_second;
  out_item_t   hash_backlog [$];

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void reseed();
    a_first  = SEED_FIRST_INIT;
    a_second = SEED_SECOND_INIT;
    b_first  = SEED_FIRST_INIT;
    b_second = SEED_SECOND_INIT;
  endfunction

  // Fold ASCII lower case, then advance chain A (row 0-255) and chain B (row 256-511).
  function automatic void churn_byte(input logic [7:0] raw);
    logic [7:0]  c;
    logic [31:0] nxt;
    c = (raw >= 8'h61 && raw <= 8'h7A) ? raw - 8'h20 : raw;
    nxt      = crypt_shadow[{1'b0, c}] ^ (a_first + a_second);
    a_second = {24'b0, c} + nxt + a_second + (a_second << 5) + 32'd3;
    a_first  = nxt;
    nxt      = crypt_shadow[{1'b1, c}] ^ (b_first + b_second);
    b_second = {24'b0, c} + nxt + b_second + (b_second << 5) + 32'd3;
    b_first  = nxt;
  endfunction

  // Each code unit on its own: 1, 2 or 3 UTF-8 bytes, surrogates as plain units.
  function automatic void absorb_unit(input logic [15:0] u);
    if (u < 16'h0080) begin
      churn_byte({1'b0, u[6:0]});
    end else if (u < 16'h0800) begin
      churn_byte({3'b110, u[10:6]});
      churn_byte({2'b10, u[5:0]});
    end else begin
      churn_byte({4'b1110, u[15:12]});
      churn_byte({2'b10, u[11:6]});
      churn_byte({2'b10, u[5:0]});
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      reseed();
      hash_backlog.delete();
      awaiting   = 0;
      mismatches = 0;
    end else begin
      // Results leave before this edge's input can add to the backlog.
      if (out_valid && out_ready) begin
        if (hash_backlog.size() == 0) begin
          flag_mismatch($sformatf("result %08h_%08h with nothing expected",
                                  out_data.hash_a, out_data.hash_b));
        end else begin
          want = hash_backlog.pop_front();
          if (out_data.hash_a !== want.hash_a) begin
            flag_mismatch($sformatf("hash_a %08h, expected %08h",
                                    out_data.hash_a, want.hash_a));
          end
          if (out_data.hash_b !== want.hash_b) begin
            flag_mismatch($sformatf("hash_b %08h, expected %08h",
                                    out_data.hash_b, want.hash_b));
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_data.command)
          CMD_LOAD:   crypt_shadow[in_data.table_index] = in_data.table_word;
          CMD_START:  reseed();
          CMD_FEED:   absorb_unit(in_data.code_unit);
          CMD_FINISH: begin
            fresh.hash_a = a_first;
            fresh.hash_b = b_first;
            hash_backlog.push_back(fresh);
          end
          default: ;
        endcase
      end
      awaiting = hash_backlog.size();
    end
  end

endmodule

>>> tb/sv/utf8_mpq_string_hash_tb.sv
// ----------------------------------------------------------------------------
// utf8_mpq_string_hash_tb: regression for the UTF-8 MPQ string hash
// Loads the whole crypt table, runs directed corner strings, a back-pressure
// burst and random strings, with a side checker scoring every result beat.
// ----------------------------------------------------------------------------
module utf8_mpq_string_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import umpq_pkg::*;

  // Run shape. After one opening finish, TableDepth beats bring up the table;
  // the last CalmTail beats go with no idling on either side.
  localparam int unsigned TotalBeats     = 1800;
  localparam int unsigned CalmTail       = 200;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned DrainCycles    = 24;
  localparam int unsigned RunLimitNs     = 2_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  int unsigned mismatches;
  int unsigned awaiting;

  int unsigned beats_sent;
  logic        gaps_on;     // sender may idle between beats
  logic        stalls_on;   // receiver may drop out_ready in bursts
  logic        long_hold;   // ask the receiver for one long hold-off

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  utf8_mpq_string_hash uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  utf8_mpq_string_hash_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // Pick a code unit, weighted so that every UTF-8 length, the case-fold
  // range, the surrogate block and the encoding boundaries all show up often.
  function automatic logic [15:0] pick_unit();
    logic [15:0] u;
    case ($urandom_range(0, 5))
      0: u = 16'h0061 + 16'($urandom_range(0, 25));
      1: u = 16'($urandom_range(0, 127));
      2: u = 16'($urandom_range(128, 2047));
      3: u = 16'($urandom_range(2048, 65535));
      4: u = 16'($urandom_range(16'hD800, 16'hDFFF));
      default: begin
        case ($urandom_range(0, 7))
          0: u = 16'h0000;
          1: u = 16'h007F;
          2: u = 16'h0080;
          3: u = 16'h07FF;
          4: u = 16'h0800;
          5: u = 16'hFFFF;
          6: u = 16'h0060;
          default: u = 16'h007B;
        endcase
      end
    endcase
    return u;
  endfunction

  // Build a beat. Fields the command does not use carry random junk so the
  // block has to ignore them.
  function automatic in_item_t make_beat(input cmd_t c, input logic [15:0] unit);
    in_item_t b;
    b.command     = c;
    b.table_index = 9'($urandom);
    b.table_word  = $urandom;
    b.code_unit   = (c == CMD_FEED) ? unit : 16'($urandom);
    return b;
  endfunction

  // Offer one beat and hold it until the handshake completes. Entered and
  // left at a falling edge, so each call makes at most one assignment to
  // in_valid per time step.
  task automatic push_beat(input in_item_t b);
    if (beats_sent + CalmTail >= TotalBeats) begin
      gaps_on = 1'b0;
      stalls_on <= 1'b0;
    end
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(input logic [8:0] idx, input logic [31:0] word);
    in_item_t b;
    b = make_beat(CMD_LOAD, 16'h0000);
    b.table_index = idx;
    b.table_word  = word;
    push_beat(b);
  endtask

  task automatic send_cmd(input cmd_t c);
    push_beat(make_beat(c, 16'h0000));
  endtask

  task automatic send_feed(input logic [15:0] u);
    push_beat(make_beat(CMD_FEED, u));
  endtask

  // One well-formed string: start, n random units, finish.
  task automatic send_string(input int unsigned n);
    send_cmd(CMD_START);
    repeat (n) send_feed(pick_unit());
    send_cmd(CMD_FINISH);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request. Every
  // iteration drives out_ready once and then moves at least one falling edge.
  initial begin
    bit hold_served;
    hold_served = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (long_hold && !hold_served) begin
        out_ready <= 1'b0;
        hold_served = 1'b1;
        repeat (LongHoldCycles) @(negedge clk);
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #RunLimitNs;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int unsigned pick;
    logic [31:0] word;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    gaps_on    = 1'b1;
    beats_sent = 0;
    stalls_on <= 1'b1;
    long_hold <= 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty string straight out of reset: no table read, seeds at reset.
    send_cmd(CMD_FINISH);

    // Bring up the whole table so no feed ever reads an unwritten word.
    // Pin the first word at zero and the last at all ones.
    for (int i = 0; i < TableDepth; i++) begin
      if (i == 0) begin
        word = 32'h0000_0000;
      end else if (i == TableDepth - 1) begin
        word = 32'hFFFF_FFFF;
      end else begin
        word = $urandom;
      end
      send_load(9'(i), word);
    end

    // Feed and finish with no start: keep hashing from the reset seeds.
    send_feed(16'h0061);
    send_cmd(CMD_FINISH);
    // Empty string after a start.
    send_cmd(CMD_START);
    send_cmd(CMD_FINISH);
    // Encoding boundaries, surrogates and the edges of the case-fold range.
    send_cmd(CMD_START);
    send_feed(16'h0000);
    send_feed(16'h007F);
    send_feed(16'h0080);
    send_feed(16'h07FF);
    send_feed(16'h0800);
    send_feed(16'hFFFF);
    send_feed(16'hD800);
    send_feed(16'hDFFF);
    send_feed(16'h007A);
    send_feed(16'h007B);
    send_feed(16'h0060);
    send_feed(16'h0041);
    send_cmd(CMD_FINISH);
    // Finish leaves the seeds alone: continue the string, finish again.
    send_feed(16'h0071);
    send_cmd(CMD_FINISH);
    send_cmd(CMD_FINISH);

    // Back-pressure: the receiver holds off while finishes pile up behind
    // the output register, so in_ready has to drop.
    long_hold <= 1'b1;
    send_string(2);
    send_cmd(CMD_FINISH);
    send_cmd(CMD_FINISH);
    send_string(1);
    send_cmd(CMD_FINISH);
    send_string(0);

    // Random part: mostly whole strings, the rest loose commands and table
    // rewrites.
    while (beats_sent < TotalBeats) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_string($urandom_range(0, 8));
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send_feed(pick_unit());
          send_cmd(CMD_FINISH);
        end
      end else if (pick < 84) begin
        send_load(9'($urandom), $urandom);
      end else if (pick < 92) begin
        send_feed(pick_unit());
      end else if (pick < 96) begin
        send_cmd(CMD_FINISH);
      end else begin
        send_cmd(CMD_START);
      end
    end

    // Drop valid, wait out the backlog, then give the pipe time to settle.
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
